/* src/ppisl_pkg.sv */
`timescale 1ns / 1ps
package ppisl_pkg;

  // decoded i/o port numbers
  localparam logic [7:0] PORT_FDC_TC     = 8'hF8;
  localparam logic [7:0] PORT_FDC_STATUS = 8'hFA;
  localparam logic [7:0] PORT_FDC_DATA   = 8'hFB;
  localparam logic [7:0] PORT_A          = 8'hFC;
  localparam logic [7:0] PORT_B          = 8'hFD;
  localparam logic [7:0] PORT_C          = 8'hFE;
  localparam logic [7:0] PORT_CTRL       = 8'hFF;

  localparam logic [7:0]  READ_UNMAPPED   = 8'hFF;
  localparam logic [15:0] LINK_WORD_RESET = 16'hFFFF;
  localparam int          CTRL_MODE_BIT   = 7;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    FDC_NONE  = 2'd0,
    FDC_READ  = 2'd1,
    FDC_WRITE = 2'd2,
    FDC_TC    = 2'd3
  } fdc_req_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  port_address;
    logic [7:0]  write_data;
    logic [7:0]  fdc_read_data;
    logic [3:0]  fdc_main_status;
    logic [15:0] link_input_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    fdc_req_t    fdc_request;
    logic        fdc_port_select;
    logic [15:0] link_word;
    logic        link_send;
  } out_item_t;

  // input stage to decode: a request is held and moves on this cycle
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

/* src/ppisl_ifs.sv */
`timescale 1ns / 1ps
interface ppisl_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  port_address;
  logic [7:0]  write_data;
  logic [7:0]  fdc_read_data;
  logic [3:0]  fdc_main_status;
  logic [15:0] link_input_word;

  modport source (
    output valid, action, port_address, write_data, fdc_read_data,
           fdc_main_status, link_input_word,
    input  ready
  );
  modport sink (
    input  valid, action, port_address, write_data, fdc_read_data,
           fdc_main_status, link_input_word,
    output ready
  );
endinterface

interface ppisl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [1:0]  fdc_request;
  logic        fdc_port_select;
  logic [15:0] link_word;
  logic        link_send;

  modport source (
    output valid, read_data, fdc_request, fdc_port_select, link_word, link_send,
    input  ready
  );
  modport sink (
    input  valid, read_data, fdc_request, fdc_port_select, link_word, link_send,
    output ready
  );
endinterface

/* src/ppisl_in_stage.sv */
`timescale 1ns / 1ps
module ppisl_in_stage
  import ppisl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  input  logic       slot_free,
  output stage_ctl_t ctl,
  output in_item_t   item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     advance;
  logic     take;

  assign advance   = valid_r && slot_free;
  assign in_ready  = !valid_r || advance;
  assign take      = in_valid && in_ready;
  assign valid_nxt = take || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = advance;
  assign item        = item_r;

endmodule

/* src/ppisl_decode.sv */
`timescale 1ns / 1ps
module ppisl_decode
  import ppisl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  in_item_t   item,
  output out_item_t  res
);

  logic [7:0]  port_b_r, port_b_nxt;
  logic [7:0]  port_c_r, port_c_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [15:0] last_sent_r, last_sent_nxt;
  logic        form_link;
  logic [7:0]  bit_mask;
  logic [15:0] word;

  always_comb begin
    port_b_nxt    = port_b_r;
    port_c_nxt    = port_c_r;
    ctrl_nxt      = ctrl_r;
    form_link     = 1'b0;
    bit_mask      = 8'(1) << item.write_data[3:1];
    res           = '0;
    res.fdc_request = FDC_NONE;

    if (item.action == ACT_READ) begin
      res.read_data = READ_UNMAPPED;
      case (item.port_address)
        PORT_FDC_TC: begin
          res.fdc_request = FDC_TC;
        end
        PORT_FDC_STATUS, PORT_FDC_DATA: begin
          res.fdc_request     = FDC_READ;
          res.fdc_port_select = (item.port_address == PORT_FDC_DATA);
          res.read_data       = item.fdc_read_data;
        end
        PORT_A:    res.read_data = item.link_input_word[7:0];
        PORT_C:    res.read_data = {4'h0, item.link_input_word[11:8]};
        PORT_CTRL: res.read_data = ctrl_r;
        default: ;
      endcase
    end else begin
      case (item.port_address)
        PORT_FDC_DATA: begin
          res.fdc_request     = FDC_WRITE;
          res.fdc_port_select = 1'b1;
        end
        PORT_B: begin
          port_b_nxt = item.write_data;
          form_link  = 1'b1;
        end
        PORT_CTRL: begin
          ctrl_nxt = item.write_data;
          if (!item.write_data[CTRL_MODE_BIT]) begin
            // single bit set/reset of port c
            port_c_nxt = item.write_data[0] ? (port_c_r | bit_mask)
                                            : (port_c_r & ~bit_mask);
            form_link  = 1'b1;
          end else begin
            port_c_nxt = '0;
          end
        end
        default: ;
      endcase
    end

    word          = {item.fdc_main_status, port_c_nxt[7:4], port_b_nxt};
    last_sent_nxt = last_sent_r;
    if (form_link) begin
      res.link_word = word;
      res.link_send = (word != last_sent_r);
      last_sent_nxt = word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_b_r    <= '0;
      port_c_r    <= '0;
      ctrl_r      <= '0;
      last_sent_r <= LINK_WORD_RESET;
    end else if (ctl.advance) begin
      port_b_r    <= port_b_nxt;
      port_c_r    <= port_c_nxt;
      ctrl_r      <= ctrl_nxt;
      last_sent_r <= last_sent_nxt;
    end
  end

  a_read_no_link: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && item.action == ACT_READ) |-> (!res.link_send && res.link_word == '0))
    else $error("link word formed on a read");

  a_send_differs: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && res.link_send) |-> (res.link_word != last_sent_r))
    else $error("link send on unchanged word");

  a_send_updates: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && res.link_send) |=> (last_sent_r == $past(res.link_word)))
    else $error("last sent word not updated");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !ctl.advance) |=> ($stable(port_b_r) && $stable(port_c_r)
                                 && $stable(ctrl_r) && $stable(last_sent_r)))
    else $error("port state changed without a request");

endmodule

/* src/ppisl_out_stage.sv */
`timescale 1ns / 1ps
module ppisl_out_stage
  import ppisl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  out_item_t  res,
  output logic       slot_free,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  logic      valid_r, valid_nxt;
  out_item_t res_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = ctl.advance || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = res_r;

endmodule

/* src/ppi_port_bridge_to_shift_link_core.sv */
`timescale 1ns / 1ps
// parallel-port bridge of the disk unit toward the serial shift link
// in_ch carries one cpu i/o request per transfer: read or write, port number,
// write byte, and the floppy controller read byte, status nibble and the
// sampled input shift word that belong to that access
// out_ch returns one result per request: read byte, floppy controller request
// and register select, and the 16-bit link word with its send flag
// a request is held in the input register, is decoded against the port b,
// port c, control and last-sent registers, and lands in the output register
// once that register is free; out_ch valid rises when the output register
// takes the result
// throughput is one request per cycle while the receiver keeps out_ch ready
// high; the state registers update in the same cycle the request moves to the
// output register, so back-to-back requests see each other's effects in order
// when the receiver stalls, the output register holds its result and the input
// register can still take one more request before in_ch ready drops
// reset clears both stages, port b, port c and the control word, and sets the
// last-sent word to all ones
module ppi_port_bridge_to_shift_link_core
  import ppisl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ppisl_in_if.sink    in_ch,
  ppisl_out_if.source out_ch
);

  in_item_t   in_item;
  in_item_t   item;
  stage_ctl_t ctl;
  out_item_t  res;
  out_item_t  out_item;
  logic       slot_free;

  assign in_item.action          = in_ch.action;
  assign in_item.port_address    = in_ch.port_address;
  assign in_item.write_data      = in_ch.write_data;
  assign in_item.fdc_read_data   = in_ch.fdc_read_data;
  assign in_item.fdc_main_status = in_ch.fdc_main_status;
  assign in_item.link_input_word = in_ch.link_input_word;

  ppisl_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .slot_free (slot_free),
    .ctl       (ctl),
    .item      (item)
  );

  ppisl_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (item),
    .res   (res)
  );

  ppisl_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  assign out_ch.read_data       = out_item.read_data;
  assign out_ch.fdc_request     = out_item.fdc_request;
  assign out_ch.fdc_port_select = out_item.fdc_port_select;
  assign out_ch.link_word       = out_item.link_word;
  assign out_ch.link_send       = out_item.link_send;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
  import ppisl_pkg::*;

  class ppi_result_tracker;
    logic [7:0]  port_b;
    logic [7:0]  port_c;
    logic [7:0]  ctrl_word;
    logic [15:0] last_sent;
    out_item_t   pending[$];
    int unsigned errors;

    function new();
      port_b    = '0;
      port_c    = '0;
      ctrl_word = '0;
      last_sent = LINK_WORD_RESET;
      errors    = 0;
    endfunction

    function void form_link(logic [3:0] status, inout out_item_t res);
      res.link_word = {status, port_c[7:4], port_b};
      res.link_send = (res.link_word != last_sent);
      last_sent     = res.link_word;
    endfunction

    function out_item_t decode_access(in_item_t req);
      out_item_t  res;
      logic [7:0] mask;
      res = '0;
      if (req.action == ACT_READ) begin
        res.read_data = READ_UNMAPPED;
        case (req.port_address)
          PORT_FDC_TC: res.fdc_request = FDC_TC;
          PORT_FDC_STATUS, PORT_FDC_DATA: begin
            res.fdc_request     = FDC_READ;
            res.fdc_port_select = (req.port_address == PORT_FDC_DATA);
            res.read_data       = req.fdc_read_data;
          end
          PORT_A: res.read_data = req.link_input_word[7:0];
          PORT_C: res.read_data = {4'h0, req.link_input_word[11:8]};
          PORT_CTRL: res.read_data = ctrl_word;
          default: ;
        endcase
      end else begin
        case (req.port_address)
          PORT_FDC_DATA: begin
            res.fdc_request     = FDC_WRITE;
            res.fdc_port_select = 1'b1;
          end
          PORT_B: begin
            port_b = req.write_data;
            form_link(req.fdc_main_status, res);
          end
          PORT_CTRL: begin
            ctrl_word = req.write_data;
            if (!req.write_data[CTRL_MODE_BIT]) begin
              // single bit set/reset of port c
              mask = 8'h01 << req.write_data[3:1];
              if (req.write_data[0]) port_c = port_c | mask;
              else port_c = port_c & ~mask;
              form_link(req.fdc_main_status, res);
            end else begin
              port_c = '0;
            end
          end
          default: ;
        endcase
      end
      return res;
    endfunction

    function void note_request(in_item_t req);
      pending.push_back(decode_access(req));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("result arrived with no request pending");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data expected %h actual %h", want.read_data, got.read_data);
        errors++;
      end
      if (got.fdc_request !== want.fdc_request) begin
        $error("fdc_request expected %0d actual %0d", want.fdc_request, got.fdc_request);
        errors++;
      end
      if (got.fdc_port_select !== want.fdc_port_select) begin
        $error("fdc_port_select expected %b actual %b", want.fdc_port_select,
               got.fdc_port_select);
        errors++;
      end
      if (got.link_word !== want.link_word) begin
        $error("link_word expected %h actual %h", want.link_word, got.link_word);
        errors++;
      end
      if (got.link_send !== want.link_send) begin
        $error("link_send expected %b actual %b", want.link_send, got.link_send);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int          PHASE_ITEMS  = 540;
  localparam int          DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  logic [7:0] last_port_b;
  logic [3:0] cur_status;

  ppisl_in_if  in_ch ();
  ppisl_out_if out_ch ();

  ppi_result_tracker tracker = new();

  ppi_port_bridge_to_shift_link_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ppi_port_bridge_to_shift_link_core regression: fail");
    $finish;
  end

  // result side: signals are settled at the falling edge, a handshake seen
  // there completes at the next rising edge
  always @(negedge clk) begin : result_sink
    out_item_t got;
    if (out_ch.valid && out_ch.ready) begin
      got.read_data       = out_ch.read_data;
      got.fdc_request     = fdc_req_t'(out_ch.fdc_request);
      got.fdc_port_select = out_ch.fdc_port_select;
      got.link_word       = out_ch.link_word;
      got.link_send       = out_ch.link_send;
      tracker.check_result(got);
    end
  end

  always @(posedge clk) begin : result_ready
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic in_item_t make_access(logic act, logic [7:0] port, logic [7:0] wdata,
                                           logic [7:0] fdata, logic [3:0] status,
                                           logic [15:0] link_in);
    in_item_t req;
    req.action          = act;
    req.port_address    = port;
    req.write_data      = wdata;
    req.fdc_read_data   = fdata;
    req.fdc_main_status = status;
    req.link_input_word = link_in;
    return req;
  endfunction

  function automatic in_item_t random_access();
    in_item_t    req;
    int unsigned pick;
    req.action          = ACT_WRITE;
    req.port_address    = 8'($urandom_range(255));
    req.write_data      = 8'($urandom_range(255));
    req.fdc_read_data   = 8'($urandom_range(255));
    req.link_input_word = 16'($urandom_range(65535));
    // status changes rarely so repeated link words come up
    if ($urandom_range(99) < 20) cur_status = 4'($urandom_range(15));
    req.fdc_main_status = cur_status;
    pick = $urandom_range(99);
    if (pick < 15) begin
      req.action       = ACT_READ;
      req.port_address = PORT_FDC_TC + 8'($urandom_range(7));
    end else if (pick < 25) begin
      req.action = ACT_READ;
    end else if (pick < 50) begin
      req.port_address = PORT_B;
      if ($urandom_range(99) < 40) req.write_data = last_port_b;
      last_port_b = req.write_data;
    end else if (pick < 78) begin
      req.port_address = PORT_CTRL;
      req.write_data[CTRL_MODE_BIT] = ($urandom_range(99) < 12);
    end else if (pick < 88) begin
      req.port_address = PORT_FDC_DATA;
    end
    return req;
  endfunction

  task automatic send_request(in_item_t req);
    in_ch.valid           <= 1'b1;
    in_ch.action          <= req.action;
    in_ch.port_address    <= req.port_address;
    in_ch.write_data      <= req.write_data;
    in_ch.fdc_read_data   <= req.fdc_read_data;
    in_ch.fdc_main_status <= req.fdc_main_status;
    in_ch.link_input_word <= req.link_input_word;
    // ready is settled at the falling edge before the edge that takes the request
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    tracker.note_request(req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.action          = 1'b0;
    in_ch.port_address    = '0;
    in_ch.write_data      = '0;
    in_ch.fdc_read_data   = '0;
    in_ch.fdc_main_status = '0;
    in_ch.link_input_word = '0;
    out_ch.ready          = 1'b0;
    rst_n                 = 1'b0;
    last_port_b           = '0;
    cur_status            = '0;
    send_idle_pct         = 35;
    recv_idle_pct         = 69;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // read decode of every port
    send_request(make_access(ACT_READ, PORT_FDC_TC, 8'h00, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_READ, PORT_FDC_STATUS, 8'h00, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_READ, PORT_FDC_DATA, 8'hFF, 8'hFF, 4'hF, 16'hFFFF));
    send_request(make_access(ACT_READ, PORT_A, 8'h00, 8'h00, 4'h0, 16'hFFFF));
    send_request(make_access(ACT_READ, PORT_C, 8'h00, 8'h00, 4'h0, 16'hFFFF));
    send_request(make_access(ACT_READ, PORT_C, 8'hFF, 8'hFF, 4'hF, 16'h0000));
    send_request(make_access(ACT_READ, PORT_CTRL, 8'h00, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_READ, 8'h00, 8'h00, 8'h5A, 4'h0, 16'h0000));
    send_request(make_access(ACT_READ, PORT_B, 8'h00, 8'hA5, 4'h0, 16'h0000));
    // writes: controller, port b with an unchanged word, bit set/reset
    send_request(make_access(ACT_WRITE, PORT_FDC_DATA, 8'hFF, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_WRITE, PORT_B, 8'h00, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_WRITE, PORT_B, 8'h00, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_WRITE, PORT_CTRL, 8'h0F, 8'h00, 4'hF, 16'h0000));
    send_request(make_access(ACT_WRITE, PORT_CTRL, 8'h0E, 8'h00, 4'hF, 16'h0000));
    send_request(make_access(ACT_WRITE, PORT_CTRL, 8'h09, 8'h00, 4'hF, 16'h0000));
    // low nibble of port c does not reach the link word
    send_request(make_access(ACT_WRITE, PORT_CTRL, 8'h01, 8'h00, 4'hF, 16'h0000));
    send_request(make_access(ACT_READ, PORT_CTRL, 8'h00, 8'h00, 4'h0, 16'h0000));
    // mode bit set clears port c without forming a word
    send_request(make_access(ACT_WRITE, PORT_CTRL, 8'h80, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_WRITE, PORT_CTRL, 8'hFF, 8'hFF, 4'hF, 16'hFFFF));
    send_request(make_access(ACT_WRITE, PORT_B, 8'hFF, 8'hFF, 4'hF, 16'hFFFF));
    // ignored write ports
    send_request(make_access(ACT_WRITE, PORT_FDC_STATUS, 8'hFF, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_WRITE, 8'hF4, 8'hFF, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_WRITE, 8'hF7, 8'hFF, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_WRITE, PORT_FDC_TC, 8'hFF, 8'h00, 4'h0, 16'h0000));
    send_request(make_access(ACT_WRITE, 8'h00, 8'hFF, 8'h00, 4'h0, 16'h0000));
    last_port_b = 8'hFF;
    cur_status  = 4'hF;

    repeat (PHASE_ITEMS) send_request(random_access());
    send_idle_pct = 69;
    recv_idle_pct = 35;
    repeat (PHASE_ITEMS) send_request(random_access());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ITEMS) send_request(random_access());
    in_ch.valid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("ppi_port_bridge_to_shift_link_core regression: pass");
    end else begin
      $display("ppi_port_bridge_to_shift_link_core regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/ppisl_pkg.sv
src/ppisl_ifs.sv
src/ppisl_in_stage.sv
src/ppisl_decode.sv
src/ppisl_out_stage.sv
src/ppi_port_bridge_to_shift_link_core.sv
verif/tb.sv
